// ===== rtl/crrd_pkg.sv =====
`timescale 1ns / 1ps

package crrd_pkg;

	// Default sizing, handed down through the top-level parameters
	localparam int unsigned MAX_SUBSCRIBERS_DEF = 8;
	localparam int unsigned QUEUE_DEPTH_DEF     = 16;
	localparam int unsigned HANDLE_WIDTH_DEF    = 32;

	// At most this many result words per command word
	localparam int unsigned RESULT_LIMIT = 16;

	typedef enum logic [1:0] {
		OP_ENQUEUE     = 2'd0,
		OP_SUBSCRIBE   = 2'd1,
		OP_FLOW        = 2'd2,
		OP_UNSUBSCRIBE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_DELIVER = 2'd0,
		KIND_ACK     = 2'd1,
		KIND_DROP    = 2'd2
	} kind_t;

	typedef struct packed {
		op_t         operation;
		logic [2:0]  subscriber;
		logic [15:0] credit;
		logic [31:0] message;
	} cmd_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  target;
		logic [31:0] payload;
		logic        last;
	} result_t;

	typedef struct packed {
		logic push;
		logic pop;
	} store_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} store_sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WRAP,
		ST_READ,
		ST_EVAL,
		ST_NEXT,
		ST_UNSUB,
		ST_FINISH
	} state_t;

endpackage

// ===== rtl/credit_round_robin_dispatcher.sv =====
`timescale 1ns / 1ps

// Channel  | Ports                    | Handshake
// ---------+--------------------------+----------------------------------------------
// command  | start, busy, cmd         | word taken at a rising edge with start & !busy
// result   | strobe, result           | word valid for the one cycle strobe is high
//
// Unsubscribe runs a pointer search when it removes the subscriber under the turn
// pointer. Enqueue and flow visit subscribers in turn, each visit using the shared
// search unit to step over inactive indices to the next active one; a wrap to the
// lowest subscriber runs its own search first.
// Reset (arst_n low) clears all control state at once; no clearing pass runs.
// The result receiver cannot stall: each word is shown for exactly one cycle.
module credit_round_robin_dispatcher #(
	parameter int unsigned MAX_SUBSCRIBERS = crrd_pkg::MAX_SUBSCRIBERS_DEF,
	parameter int unsigned QUEUE_DEPTH     = crrd_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned HANDLE_WIDTH    = crrd_pkg::HANDLE_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  crrd_pkg::cmd_t    cmd,
	output logic              strobe,
	output crrd_pkg::result_t result
);

	localparam int unsigned IW = $clog2(MAX_SUBSCRIBERS);
	localparam int unsigned PW = $clog2(MAX_SUBSCRIBERS + 1);
	localparam int unsigned KW = $clog2(crrd_pkg::RESULT_LIMIT + 1);
	localparam logic [PW-1:0] PTR_END = PW'(MAX_SUBSCRIBERS);
	localparam logic [KW-1:0] K_LIMIT = KW'(crrd_pkg::RESULT_LIMIT);

	crrd_pkg::state_t state_q, state_d;

	// Subscriber table: active flags in flip-flops, credits in a small memory.
	// A credit entry is written on every activation, so an inactive entry is
	// never read and needs no reset.
	logic [MAX_SUBSCRIBERS-1:0] active_q;
	logic [15:0]                credit_mem [MAX_SUBSCRIBERS];
	logic [15:0]                cred_rd_q;
	logic                       cred_we;
	logic [IW-1:0]              cred_waddr;
	logic [15:0]                cred_wdata;

	logic [PW-1:0] ptr_q;
	logic [PW-1:0] n_act_q;
	logic [PW-1:0] misses_q;
	logic [KW-1:0] k_q;
	logic [2:0]    sub_q;

	// Result staging: hold one word back so the final one can carry last
	logic              pend_valid_q;
	crrd_pkg::result_t pend_q;
	crrd_pkg::result_t result_q;
	logic              strobe_q;

	// Decoded command
	logic                    accept;
	logic                    sub_ok;
	logic [IW-1:0]           sub_idx;
	logic [PW-1:0]           sub_ptr;
	logic [HANDLE_WIDTH-1:0] msg_h;

	// Sequencer controls
	logic              act_set, act_clr;
	logic              ptr_load;
	logic [PW-1:0]     ptr_d;
	logic              misses_clr, misses_inc;
	logic              emit, flush;
	crrd_pkg::result_t emit_r;

	// Shared search unit
	logic          scan_start;
	logic [PW-1:0] scan_from;
	logic          scan_done;
	logic [PW-1:0] scan_index;

	// Message FIFO
	crrd_pkg::store_ctl_t    store_ctl;
	crrd_pkg::store_sts_t    store_sts;
	logic [HANDLE_WIDTH-1:0] store_rdata;

	assign busy    = (state_q != crrd_pkg::ST_IDLE);
	assign accept  = start && !busy;
	assign sub_ok  = ({29'd0, cmd.subscriber} < 32'(MAX_SUBSCRIBERS));
	assign sub_idx = IW'(cmd.subscriber);
	assign sub_ptr = PW'(cmd.subscriber);
	assign msg_h   = HANDLE_WIDTH'(cmd.message);
	assign strobe  = strobe_q;
	assign result  = result_q;

	crrd_scan #(
		.MAX_SUBSCRIBERS(MAX_SUBSCRIBERS)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.start (scan_start),
		.from  (scan_from),
		.active(active_q),
		.done  (scan_done),
		.index (scan_index)
	);

	crrd_store #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.HANDLE_WIDTH(HANDLE_WIDTH)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (store_ctl),
		.wdata (msg_h),
		.rdata (store_rdata),
		.sts   (store_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crrd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state and the strobes that drive the datapath
	always_comb begin
		state_d    = state_q;
		act_set    = 1'b0;
		act_clr    = 1'b0;
		ptr_load   = 1'b0;
		ptr_d      = ptr_q;
		misses_clr = 1'b0;
		misses_inc = 1'b0;
		emit       = 1'b0;
		emit_r     = '0;
		flush      = 1'b0;
		scan_start = 1'b0;
		scan_from  = '0;
		store_ctl  = '0;
		cred_we    = 1'b0;
		cred_waddr = sub_idx;
		cred_wdata = '0;

		case (state_q)
			crrd_pkg::ST_IDLE: begin
				if (accept) begin
					misses_clr = 1'b1;
					case (cmd.operation)
						crrd_pkg::OP_ENQUEUE: begin
							// Full queue: drop and report, then still dispatch
							if (store_sts.full) begin
								emit           = 1'b1;
								emit_r.kind    = crrd_pkg::KIND_DROP;
								emit_r.payload = 32'(msg_h);
							end else begin
								store_ctl.push = 1'b1;
							end
							state_d = crrd_pkg::ST_CHECK;
						end
						crrd_pkg::OP_SUBSCRIBE: begin
							if (sub_ok) begin
								act_set = 1'b1;
								cred_we = 1'b1;
							end
							state_d = crrd_pkg::ST_FINISH;
						end
						crrd_pkg::OP_FLOW: begin
							if (sub_ok) begin
								act_set    = 1'b1;
								cred_we    = 1'b1;
								cred_wdata = cmd.credit;
								state_d    = crrd_pkg::ST_CHECK;
							end else begin
								state_d = crrd_pkg::ST_FINISH;
							end
						end
						crrd_pkg::OP_UNSUBSCRIBE: begin
							act_clr = sub_ok;
							if (sub_ok && ptr_q == sub_ptr) begin
								// Move the pointer past the leaving subscriber first
								scan_start = 1'b1;
								scan_from  = sub_ptr + 1'b1;
								state_d    = crrd_pkg::ST_UNSUB;
							end else begin
								emit          = 1'b1;
								emit_r.kind   = crrd_pkg::KIND_ACK;
								emit_r.target = cmd.subscriber;
								state_d       = crrd_pkg::ST_FINISH;
							end
						end
						default: begin
							state_d = crrd_pkg::ST_FINISH;
						end
					endcase
				end
			end
			crrd_pkg::ST_CHECK: begin
				// Stop on empty queue, a full pass without credit, or the word limit
				if (store_sts.empty || misses_q >= n_act_q || k_q >= K_LIMIT) begin
					state_d = crrd_pkg::ST_FINISH;
				end else if (ptr_q == PTR_END) begin
					scan_start = 1'b1;
					scan_from  = '0;
					state_d    = crrd_pkg::ST_WRAP;
				end else begin
					state_d = crrd_pkg::ST_EVAL;
				end
			end
			crrd_pkg::ST_WRAP: begin
				if (scan_done) begin
					ptr_load = 1'b1;
					ptr_d    = scan_index;
					state_d  = (scan_index == PTR_END) ? crrd_pkg::ST_FINISH
					                                   : crrd_pkg::ST_READ;
				end
			end
			crrd_pkg::ST_READ: begin
				state_d = crrd_pkg::ST_EVAL;
			end
			crrd_pkg::ST_EVAL: begin
				if (cred_rd_q != '0) begin
					emit           = 1'b1;
					emit_r.kind    = crrd_pkg::KIND_DELIVER;
					emit_r.target  = 3'(ptr_q);
					emit_r.payload = 32'(store_rdata);
					store_ctl.pop  = 1'b1;
					cred_we        = 1'b1;
					cred_waddr     = ptr_q[IW-1:0];
					cred_wdata     = cred_rd_q - 1'b1;
					misses_clr     = 1'b1;
				end else begin
					misses_inc = 1'b1;
				end
				scan_start = 1'b1;
				scan_from  = ptr_q + 1'b1;
				state_d    = crrd_pkg::ST_NEXT;
			end
			crrd_pkg::ST_NEXT: begin
				if (scan_done) begin
					ptr_load = 1'b1;
					ptr_d    = scan_index;
					state_d  = crrd_pkg::ST_CHECK;
				end
			end
			crrd_pkg::ST_UNSUB: begin
				if (scan_done) begin
					ptr_load      = 1'b1;
					ptr_d         = scan_index;
					emit          = 1'b1;
					emit_r.kind   = crrd_pkg::KIND_ACK;
					emit_r.target = sub_q;
					state_d       = crrd_pkg::ST_FINISH;
				end
			end
			crrd_pkg::ST_FINISH: begin
				flush   = 1'b1;
				state_d = crrd_pkg::ST_IDLE;
			end
			default: begin
				state_d = crrd_pkg::ST_IDLE;
			end
		endcase
	end

	// Credit memory: one write port, registered read at the turn pointer
	always_ff @(posedge clk) begin
		if (cred_we) begin
			credit_mem[cred_waddr] <= cred_wdata;
		end
		cred_rd_q <= credit_mem[ptr_q[IW-1:0]];
	end

	// Control state: active flags, active count, pointer, miss and word counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			n_act_q  <= '0;
			ptr_q    <= PTR_END;
			misses_q <= '0;
			k_q      <= '0;
		end else begin
			if (act_set) begin
				active_q[sub_idx] <= 1'b1;
				if (!active_q[sub_idx]) begin
					n_act_q <= n_act_q + 1'b1;
				end
			end else if (act_clr) begin
				active_q[sub_idx] <= 1'b0;
				if (active_q[sub_idx]) begin
					n_act_q <= n_act_q - 1'b1;
				end
			end

			if (ptr_load) begin
				ptr_q <= ptr_d;
			end

			if (misses_clr) begin
				misses_q <= '0;
			end else if (misses_inc) begin
				misses_q <= misses_q + 1'b1;
			end

			// Count result words of the current command word
			if (accept) begin
				k_q <= emit ? KW'(1) : '0;
			end else if (emit) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sub_q <= cmd.subscriber;
		end
	end

	// Output staging: release the held word when a newer one arrives (not
	// last) or when the command word finishes (last)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (emit) begin
				strobe_q     <= pend_valid_q;
				pend_valid_q <= 1'b1;
			end else if (flush && pend_valid_q) begin
				strobe_q     <= 1'b1;
				pend_valid_q <= 1'b0;
			end
		end
	end

	// The held word always has last clear, since emit_r starts from zero
	always_ff @(posedge clk) begin
		if (emit) begin
			pend_q   <= emit_r;
			result_q <= pend_q;
		end else if (flush) begin
			result_q <= {pend_q.kind, pend_q.target, pend_q.payload, 1'b1};
		end
	end

endmodule

// ===== rtl/crrd_scan.sv =====
`timescale 1ns / 1ps

// Shared search unit: walks upward one subscriber index per cycle from a start
// index (inclusive) and stops on the first active one, or on the end marker.
module crrd_scan #(
	parameter int unsigned MAX_SUBSCRIBERS = crrd_pkg::MAX_SUBSCRIBERS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [$clog2(MAX_SUBSCRIBERS+1)-1:0]   from,
	input  logic [MAX_SUBSCRIBERS-1:0]             active,
	output logic                                   done,
	output logic [$clog2(MAX_SUBSCRIBERS+1)-1:0]   index
);

	localparam int unsigned IW = $clog2(MAX_SUBSCRIBERS);
	localparam int unsigned PW = $clog2(MAX_SUBSCRIBERS + 1);
	localparam logic [PW-1:0] PTR_END = PW'(MAX_SUBSCRIBERS);

	logic          busy_q;
	logic [PW-1:0] idx_q;
	logic          at_end;

	assign at_end = (idx_q == PTR_END);
	assign done   = busy_q && (at_end || active[idx_q[IW-1:0]]);
	assign index  = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= PTR_END;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= from;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			idx_q <= idx_q + 1'b1;
		end
	end

endmodule

// ===== rtl/crrd_store.sv =====
`timescale 1ns / 1ps

// Message FIFO: one write port at the tail, registered read of the head entry.
module crrd_store #(
	parameter int unsigned QUEUE_DEPTH  = crrd_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned HANDLE_WIDTH = crrd_pkg::HANDLE_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  crrd_pkg::store_ctl_t    ctl,
	input  logic [HANDLE_WIDTH-1:0] wdata,
	output logic [HANDLE_WIDTH-1:0] rdata,
	output crrd_pkg::store_sts_t    sts
);

	localparam int unsigned QW = $clog2(QUEUE_DEPTH);
	localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [QW-1:0] LAST_SLOT = QW'(QUEUE_DEPTH - 1);

	logic [HANDLE_WIDTH-1:0] mem [QUEUE_DEPTH];
	logic [QW-1:0]           head_q;
	logic [QW-1:0]           tail_q;
	logic [FW-1:0]           fill_q;
	logic [HANDLE_WIDTH-1:0] rd_q;

	assign rdata     = rd_q;
	assign sts.empty = (fill_q == '0);
	assign sts.full  = (fill_q == FW'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail_q] <= wdata;
		end
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else if (ctl.push) begin
			tail_q <= (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
			fill_q <= fill_q + 1'b1;
		end else if (ctl.pop) begin
			head_q <= (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
			fill_q <= fill_q - 1'b1;
		end
	end

endmodule
